@@ sv/divergence_bound_step_inverse_defines.svh @@
`ifndef DIVERGENCE_BOUND_STEP_INVERSE_DEFINES_SVH
`define DIVERGENCE_BOUND_STEP_INVERSE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DBSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DBSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dbsi_pkg.sv @@
package dbsi_pkg;

  localparam int DataW   = 48;
  localparam int RankW   = 13;
  localparam int RankCW  = 17;
  localparam int InW     = 256;
  localparam int WideW   = 200;
  localparam int NumW    = 100;
  localparam int DenW    = 49;
  localparam int RemW    = 104;
  localparam int SdIters = 100;
  localparam int CntW    = 7;
  localparam int QDepth  = 2;

  localparam logic [WideW-1:0] Two65 = WideW'(1) << 65;

  typedef struct packed {
    logic [DataW-1:0] d;
    logic [DataW-1:0] f;
    logic [80:0]      t2;
    logic [63:0]      fr;
    logic [DataW-1:0] lmax;
    logic [DataW-1:0] lmin;
    logic [DataW:0]   sum;
    logic [DataW-1:0] lbig;
    logic             lz;
    logic             min_skip;
    logic             max_skip;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIN_DL,
    ST_MIN_SQ,
    ST_MIN_RT,
    ST_MIN_DV,
    ST_MIN_CK,
    ST_MIN_FN,
    ST_MAX_QD,
    ST_MAX_BB,
    ST_MAX_FD,
    ST_MAX_RT,
    ST_MAX_DV,
    ST_MAX_CK,
    ST_MAX_FN,
    ST_DONE
  } state_t;

  typedef enum logic {
    SD_SQRT,
    SD_DIV
  } sd_mode_t;

endpackage

@@ sv/dbsi_front.sv @@
module dbsi_front #(
  parameter int MAX_RANK = 4096
) (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [dbsi_pkg::InW-1:0] in_tdata,
  input  logic                     q_full,
  output logic                     q_push,
  output dbsi_pkg::item_t          q_item
);
  import dbsi_pkg::*;

  localparam logic [RankCW-1:0] MaxRankC = RankCW'(MAX_RANK);

  logic [DataW-1:0]  d, f, t, lmax, lmin;
  logic [RankW-1:0]  rk;
  logic [RankCW-1:0] rc;
  logic [63:0]       frp;

  assign d    = in_tdata[47:0];
  assign f    = in_tdata[95:48];
  assign t    = in_tdata[143:96];
  assign rk   = in_tdata[156:144];
  assign lmax = in_tdata[204:157];
  assign lmin = in_tdata[252:205];

  assign rc  = (RankCW'(rk) > MaxRankC) ? MaxRankC : RankCW'(rk);
  assign frp = 64'(f) * 64'(rc);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.d        = d;
    q_item.f        = f;
    q_item.t2       = {t, 33'b0};
    q_item.fr       = frp;
    q_item.lmax     = lmax;
    q_item.lmin     = lmin;
    q_item.sum      = (DataW+1)'(lmax) + (DataW+1)'(lmin);
    q_item.lbig     = (lmax > lmin) ? lmax : lmin;
    q_item.lz       = (lmax == '0) || (lmin == '0);
    q_item.min_skip = (f == '0) || (lmin == '0);
    q_item.max_skip = (f == '0) || ((lmax == '0) && (lmin == '0));
  end

endmodule

@@ sv/dbsi_fifo.sv @@
module dbsi_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dbsi_pkg::item_t wr_item,
  input  logic            pop,
  output dbsi_pkg::item_t rd_item,
  output logic            full,
  output logic            empty
);
  import dbsi_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  item_t           mem_r [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (PtrW+1)'(QDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_item;
  end

endmodule

@@ sv/dbsi_mul.sv @@
module dbsi_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dbsi_pkg::NumW-1:0]  a,
  input  logic [dbsi_pkg::NumW-1:0]  b,
  output logic                       done,
  output logic [dbsi_pkg::WideW-1:0] p
);
  import dbsi_pkg::*;

  logic             run_r;
  logic [WideW-1:0] a_r, acc_r, pp;
  logic [NumW-1:0]  b_r;

  assign done = run_r && (b_r == '0);
  assign p    = acc_r;
  assign pp   = a_r * WideW'(b_r[3:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (done) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= WideW'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r && !done) begin
      acc_r <= acc_r + pp;
      a_r   <= a_r << 4;
      b_r   <= b_r >> 4;
    end
  end

endmodule

@@ sv/dbsi_sqdiv.sv @@
module dbsi_sqdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  dbsi_pkg::sd_mode_t         mode,
  input  logic [dbsi_pkg::WideW-1:0] rad,
  input  logic [dbsi_pkg::DenW-1:0]  den,
  output logic                       done,
  output logic [dbsi_pkg::NumW-1:0]  res
);
  import dbsi_pkg::*;

  logic             run_r;
  logic [CntW-1:0]  cnt_r;
  sd_mode_t         mode_r;
  logic [WideW-1:0] rad_r;
  logic [RemW-1:0]  rem_r, shin, sub, dif;
  logic [NumW-1:0]  root_r;
  logic [DenW-1:0]  den_r;
  logic             ge;

  assign done = run_r && (cnt_r == '0);
  assign res  = root_r;

  always_comb begin
    if (mode_r == SD_SQRT) begin
      shin = {rem_r[RemW-3:0], rad_r[WideW-1 -: 2]};
      sub  = {2'b0, root_r, 2'b01};
    end else begin
      shin = {rem_r[RemW-2:0], rad_r[WideW-1]};
      sub  = RemW'(den_r);
    end
    ge  = (shin >= sub);
    dif = shin - sub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (done) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      rad_r  <= rad;
      den_r  <= den;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CntW'(SdIters);
    end else if (run_r && !done) begin
      rem_r  <= ge ? dif : shin;
      root_r <= {root_r[NumW-2:0], ge};
      rad_r  <= (mode_r == SD_SQRT) ? (rad_r << 2) : (rad_r << 1);
      cnt_r  <= cnt_r - 1'b1;
    end
  end

endmodule

@@ sv/dbsi_back.sv @@
module dbsi_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  dbsi_pkg::item_t            q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dbsi_pkg::DataW-1:0] out_step,
  output logic                       out_found
);
  import dbsi_pkg::*;

  state_t           state_r, state_nxt;
  logic             pend_r, pend_nxt;
  item_t            it_r, it_nxt;
  logic [97:0]      bv_r, bv_nxt;
  logic [NumW-1:0]  s_r, s_nxt, num_r, num_nxt, k_r, k_nxt, best_r, best_nxt;
  logic [WideW-1:0] w_r, w_nxt;
  logic             neg_r, neg_nxt, have_r, have_nxt, second_r, second_nxt;
  logic             ov_r, ov_nxt, ofound_r, ofound_nxt;
  logic [DataW-1:0] ostep_r, ostep_nxt;

  logic             mul_go, mul_done, sd_go, sd_done;
  logic [NumW-1:0]  mul_a, mul_b, sd_res;
  logic [WideW-1:0] mul_p, sd_rad, yv, tq, fd_sum;
  sd_mode_t         sd_mode;
  logic             op_st, use_sd, fire, fin;
  state_t           nmax;

  dbsi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  dbsi_sqdiv u_sqdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sd_go),
    .mode  (sd_mode),
    .rad   (sd_rad),
    .den   ({it_r.f, 1'b0}),
    .done  (sd_done),
    .res   (sd_res)
  );

  assign yv     = {38'b0, it_r.fr, 98'b0};
  assign tq     = WideW'(it_r.t2);
  assign fd_sum = w_r + {mul_p[132:0], 67'b0};
  assign fin    = (k_r != '0) && !it_r.lz && (mul_p < Two65);
  assign nmax   = it_r.max_skip ? ST_DONE : ST_MAX_QD;

  assign out_valid = ov_r;
  assign out_step  = ostep_r;
  assign out_found = ofound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r     <= it_nxt;
    bv_r     <= bv_nxt;
    s_r      <= s_nxt;
    num_r    <= num_nxt;
    k_r      <= k_nxt;
    best_r   <= best_nxt;
    w_r      <= w_nxt;
    neg_r    <= neg_nxt;
    have_r   <= have_nxt;
    second_r <= second_nxt;
    ofound_r <= ofound_nxt;
    ostep_r  <= ostep_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    it_nxt     = it_r;
    bv_nxt     = bv_r;
    s_nxt      = s_r;
    num_nxt    = num_r;
    k_nxt      = k_r;
    best_nxt   = best_r;
    w_nxt      = w_r;
    neg_nxt    = neg_r;
    have_nxt   = have_r;
    second_nxt = second_r;
    ofound_nxt = ofound_r;
    ostep_nxt  = ostep_r;
    ov_nxt     = ov_r && !out_ready;
    q_pop      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sd_mode    = SD_SQRT;
    sd_rad     = w_r;

    op_st  = (state_r != ST_IDLE) && (state_r != ST_DONE);
    use_sd = (state_r == ST_MIN_RT) || (state_r == ST_MIN_DV) ||
             (state_r == ST_MAX_RT) || (state_r == ST_MAX_DV);
    mul_go = op_st && !pend_r && !use_sd;
    sd_go  = op_st && !pend_r && use_sd;
    fire   = pend_r && (use_sd ? sd_done : mul_done);
    if (op_st && !pend_r) pend_nxt = 1'b1;
    if (fire) pend_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          it_nxt     = q_item;
          have_nxt   = 1'b0;
          second_nxt = 1'b0;
          if (!q_item.min_skip) state_nxt = ST_MIN_DL;
          else if (!q_item.max_skip) state_nxt = ST_MAX_QD;
          else state_nxt = ST_DONE;
        end
      end
      ST_MIN_DL: begin
        mul_a = NumW'(it_r.lmin);
        mul_b = NumW'(it_r.d);
        if (fire) begin
          bv_nxt    = 98'(it_r.t2) + mul_p[97:0];
          state_nxt = ST_MIN_SQ;
        end
      end
      ST_MIN_SQ: begin
        mul_a = NumW'(bv_r);
        mul_b = NumW'(bv_r);
        if (fire) begin
          if (mul_p < yv) begin
            state_nxt = nmax;
          end else begin
            w_nxt     = mul_p - yv;
            state_nxt = ST_MIN_RT;
          end
        end
      end
      ST_MIN_RT: begin
        sd_mode = SD_SQRT;
        sd_rad  = w_r;
        if (fire) begin
          s_nxt     = sd_res;
          num_nxt   = NumW'(bv_r) + sd_res;
          state_nxt = ST_MIN_DV;
        end
      end
      ST_MIN_DV: begin
        sd_mode = SD_DIV;
        sd_rad  = {num_r, {(WideW-NumW){1'b0}}};
        if (fire) begin
          k_nxt     = sd_res;
          state_nxt = ST_MIN_CK;
        end
      end
      ST_MIN_CK: begin
        mul_a = k_r;
        mul_b = NumW'(it_r.sum);
        if (fire) begin
          if (mul_p <= Two65) begin
            state_nxt = ST_MIN_FN;
          end else if (!second_r) begin
            second_nxt = 1'b1;
            num_nxt    = NumW'(bv_r) - s_r;
            state_nxt  = ST_MIN_DV;
          end else begin
            state_nxt = nmax;
          end
        end
      end
      ST_MIN_FN: begin
        mul_a = k_r;
        mul_b = NumW'(it_r.lbig);
        if (fire) begin
          if (fin) begin
            best_nxt = k_r;
            have_nxt = 1'b1;
          end
          state_nxt = nmax;
        end
      end
      ST_MAX_QD: begin
        mul_a = NumW'(it_r.lmax);
        mul_b = NumW'(it_r.d);
        if (fire) begin
          neg_nxt   = (tq < mul_p);
          bv_nxt    = (tq < mul_p) ? 98'(mul_p - tq) : 98'(tq - mul_p);
          state_nxt = ST_MAX_BB;
        end
      end
      ST_MAX_BB: begin
        mul_a = NumW'(bv_r);
        mul_b = NumW'(bv_r);
        if (fire) begin
          w_nxt     = mul_p;
          state_nxt = ST_MAX_FD;
        end
      end
      ST_MAX_FD: begin
        mul_a = NumW'(it_r.f);
        mul_b = NumW'(it_r.d);
        if (fire) begin
          if (fd_sum < yv) begin
            state_nxt = ST_DONE;
          end else begin
            w_nxt     = fd_sum - yv;
            state_nxt = ST_MAX_RT;
          end
        end
      end
      ST_MAX_RT: begin
        sd_mode = SD_SQRT;
        sd_rad  = w_r;
        if (fire) begin
          if (neg_r && (sd_res < NumW'(bv_r))) begin
            state_nxt = ST_DONE;
          end else begin
            num_nxt   = neg_r ? (sd_res - NumW'(bv_r)) : (NumW'(bv_r) + sd_res);
            state_nxt = ST_MAX_DV;
          end
        end
      end
      ST_MAX_DV: begin
        sd_mode = SD_DIV;
        sd_rad  = {num_r, {(WideW-NumW){1'b0}}};
        if (fire) begin
          k_nxt     = sd_res;
          state_nxt = ST_MAX_CK;
        end
      end
      ST_MAX_CK: begin
        mul_a = k_r;
        mul_b = NumW'(it_r.sum);
        if (fire) begin
          if ((mul_p >= Two65) && (!have_r || (k_r > best_r))) state_nxt = ST_MAX_FN;
          else state_nxt = ST_DONE;
        end
      end
      ST_MAX_FN: begin
        mul_a = k_r;
        mul_b = NumW'(it_r.lbig);
        if (fire) begin
          if (fin) begin
            best_nxt = k_r;
            have_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          ofound_nxt = have_r;
          if (!have_r) ostep_nxt = '0;
          else if (best_r[NumW-1:DataW] != '0) ostep_nxt = '1;
          else ostep_nxt = best_r[DataW-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/divergence_bound_step_inverse.sv @@
// An accepted word enters the queue and is popped by the sequencer from idle; when neither
// branch applies, it passes straight to the done state, which registers out_tvalid.
// One word is solved at a time, on one shared radix-16 multiplier and one shift-subtract
// root/divide unit.
// A two-word queue lets the input side accept while a solve and an output word wait.
// Reset (rst_n low, synchronous) empties the queue, idles the sequencer, drops out_tvalid.
module divergence_bound_step_inverse #(
  parameter int MAX_RANK = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // divergence_bound, frob_norm_sq, eig_trace, eig_rank, eig_largest, eig_smallest, pad
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // step_size
  output logic [47:0]  out_tdata,
  // found
  output logic [0:0]   out_tuser
);
  import dbsi_pkg::*;

  `include "divergence_bound_step_inverse_defines.svh"

  item_t f_item, q_item;
  logic  q_push, q_pop, q_full, q_empty, found;

  dbsi_front #(
    .MAX_RANK (MAX_RANK)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item)
  );

  dbsi_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  dbsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_step  (out_tdata),
    .out_found (found)
  );

  assign out_tuser = found;

  `DBSI_ASSERT_NOW(a_nf_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "step without found")
  `DBSI_ASSERT_NOW(a_f_nzero, out_tvalid && out_tuser[0], out_tdata != '0, "found with zero step")
  `DBSI_ASSERT_NEXT(a_q_fill, in_tvalid && in_tready && q_empty, !q_empty, "queue lost a word")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dbsi_pkg::*;

  typedef logic [255:0] wide_t;

  typedef struct {
    logic [47:0] step;
    logic        found;
  } step_result_t;

  localparam wide_t LIMIT_TWO = wide_t'(1) << 65;
  localparam int    RANK_CAP  = 4096;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;

  step_result_t pending_steps[$];
  int           errors;
  bit           calm;

  divergence_bound_step_inverse #(.MAX_RANK(RANK_CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic wide_t floor_sqrt(input wide_t a);
    wide_t res;
    wide_t cand;
    res = '0;
    for (int b = 127; b >= 0; b--) begin
      cand = res;
      cand[b] = 1'b1;
      if (cand * cand <= a) res = cand;
    end
    return res;
  endfunction

  function automatic bit admissible(input wide_t k, input wide_t lmax, input wide_t lmin);
    if (k == 0 || lmax == 0 || lmin == 0) return 1'b0;
    return (k * lmax < LIMIT_TWO) && (k * lmin < LIMIT_TWO);
  endfunction

  function automatic step_result_t solve_step(input logic [47:0] d_in, input logic [47:0] f_in,
                                              input logic [47:0] t_in, input logic [12:0] r_in,
                                              input logic [47:0] lmax_in,
                                              input logic [47:0] lmin_in);
    wide_t d, f, t, r, lmax, lmin, sum, den, lin_term, disc, s, k1, k2, best;
    wide_t p, q, b, u, num;
    bit have, ok1, ok2, neg;
    step_result_t res;
    d = wide_t'(d_in); f = wide_t'(f_in); t = wide_t'(t_in);
    lmax = wide_t'(lmax_in); lmin = wide_t'(lmin_in);
    r = (r_in > RANK_CAP) ? wide_t'(RANK_CAP) : wide_t'(r_in);
    sum = lmax + lmin;
    den = f << 1;
    ok1 = 1'b0;
    ok2 = 1'b0;
    k1 = '0;
    k2 = '0;
    if (f != 0 && lmin != 0) begin
      lin_term = (t << 33) + d * lmin;
      disc = lin_term * lin_term;
      if (disc >= ((f * r) << 98)) begin
        s = floor_sqrt(disc - ((f * r) << 98));
        k1 = (lin_term + s) / den;
        if (k1 * sum <= LIMIT_TWO) ok1 = 1'b1;
        else begin
          k1 = (lin_term - s) / den;
          ok1 = (k1 * sum <= LIMIT_TWO);
        end
      end
    end
    if (f != 0 && sum != 0) begin
      p = t << 33;
      q = lmax * d;
      neg = p < q;
      b = neg ? q - p : p - q;
      u = b * b + ((f * d) << 67);
      if (u >= ((f * r) << 98)) begin
        s = floor_sqrt(u - ((f * r) << 98));
        if (!(neg && s < b)) begin
          num = neg ? s - b : b + s;
          k2 = num / den;
          ok2 = (k2 * sum >= LIMIT_TWO);
        end
      end
    end
    have = 1'b0;
    best = '0;
    if (ok1 && admissible(k1, lmax, lmin)) begin
      best = k1;
      have = 1'b1;
    end
    if (ok2 && (!have || k2 > best) && admissible(k2, lmax, lmin)) begin
      best = k2;
      have = 1'b1;
    end
    res.found = have;
    res.step = !have ? 48'd0 : (best >= (wide_t'(1) << 48)) ? '1 : best[47:0];
    return res;
  endfunction

  task automatic send_word(input logic [47:0] d, input logic [47:0] f, input logic [47:0] t,
                           input logic [12:0] r, input logic [47:0] lmax,
                           input logic [47:0] lmin);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    pending_steps.push_back(solve_step(d, f, t, r, lmax, lmin));
    in_tdata <= {3'b0, lmin, lmax, r, t, f, d};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic test_zero_divisors();
    send_word('0, '0, '0, '0, '0, '0);
    send_word(48'h1_0000_0000, '0, 48'h2_0000_0000, 13'd2, 48'h1_0000_0000, 48'h1_0000_0000);
    send_word(48'h1_0000_0000, 48'h2_0000_0000, 48'h2_0000_0000, 13'd2, 48'h1_0000_0000, '0);
    send_word(48'h1_0000_0000, 48'h2_0000_0000, 48'h2_0000_0000, 13'd2, '0, '0);
    send_word(48'h1_0000_0000, 48'h2_0000_0000, 48'h2_0000_0000, 13'd2, '0, 48'h8000_0000);
  endtask

  task automatic test_extremes();
    send_word('1, '1, '1, 13'h1FFF, '1, '1);
    send_word('1, 48'd1, '1, 13'd1, '1, 48'd1);
    send_word(48'd1, '1, 48'd1, 13'd4096, 48'd1, 48'd1);
    send_word('0, 48'h1_0000_0000, '0, 13'd1, 48'h1_0000_0000, 48'h1_0000_0000);
    send_word(48'h4000_0000, 48'h1, '1, 13'd0, 48'h100, 48'h100);
    send_word('1, 48'h1_0000_0000, '1, 13'd0, 48'h1, 48'h1);
  endtask

  task automatic test_rank_clamp();
    send_word(48'h1_0000_0000, 48'h4_0000_0000, 48'h4_0000_0000, 13'd4096, 48'h1_0000_0000,
              48'h8000_0000);
    send_word(48'h1_0000_0000, 48'h4_0000_0000, 48'h4_0000_0000, 13'd4097, 48'h1_0000_0000,
              48'h8000_0000);
    send_word(48'h1_0000_0000, 48'h4_0000_0000, 48'h4_0000_0000, 13'h1FFF, 48'h1_0000_0000,
              48'h8000_0000);
  endtask

  task automatic test_typical();
    send_word(48'h0_8000_0000, 48'h3_0000_0000, 48'h3_0000_0000, 13'd3, 48'h1_8000_0000,
              48'h0_8000_0000);
    send_word(48'h0_1000_0000, 48'h2_0000_0000, 48'h2_0000_0000, 13'd2, 48'h1_0000_0000,
              48'h1_0000_0000);
    send_word(48'h5_0000_0000, 48'h10_0000_0000, 48'h6_0000_0000, 13'd4, 48'h3_0000_0000,
              48'h0_2000_0000);
    send_word(48'h0_8000_0000, 48'h3_0000_0000, 48'h3_0000_0000, 13'd3, 48'h0_8000_0000,
              48'h1_8000_0000);
  endtask

  task automatic test_random(input int count);
    logic [127:0] lmin, lmax, t, f, r, d;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 2);
      if ($urandom_range(99) < 25) begin
        send_word(rand48(), rand48(), rand48(), 13'($urandom), rand48(), rand48());
      end else begin
        r = 128'($urandom_range(1, ($urandom_range(9) == 0) ? 5000 : 64));
        lmin = 128'($urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
        lmax = lmin + (128'($urandom) << $urandom_range(0, 4));
        t = r * lmin + 128'($urandom_range(0, r[12:0])) * (lmax - lmin);
        f = ((t * t) / r) >> 32;
        f = f + (128'($urandom) >> $urandom_range(0, 31));
        d = 128'($urandom) << $urandom_range(0, 12);
        if ($urandom_range(9) == 0) {lmin, lmax} = {lmax, lmin};
        send_word(d[47:0], f[47:0], t[47:0], r[12:0], lmax[47:0], lmin[47:0]);
      end
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n) out_tready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    step_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_steps.size() == 0) begin
        errors++;
        $display("%0t: unexpected word step=%h found=%b", $time, out_tdata, out_tuser);
      end else begin
        want = pending_steps.pop_front();
        if (out_tdata !== want.step) begin
          errors++;
          $display("%0t: step_size expected %h actual %h", $time, want.step, out_tdata);
        end
        if (out_tuser[0] !== want.found) begin
          errors++;
          $display("%0t: found expected %b actual %b", $time, want.found, out_tuser[0]);
        end
      end
    end
  end

  initial begin
    #45ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    errors = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_zero_divisors();
    test_extremes();
    test_rank_clamp();
    test_typical();
    test_random(1450);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ divergence_bound_step_inverse.f @@
+incdir+sv
sv/dbsi_pkg.sv
sv/dbsi_front.sv
sv/dbsi_fifo.sv
sv/dbsi_mul.sv
sv/dbsi_sqdiv.sv
sv/dbsi_back.sv
sv/divergence_bound_step_inverse.sv
bench/tb_top.sv
